@@ rtl/hsv2rgb_pkg.sv @@
// Shared types, constants and term selection for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

  // Output channel width; full scale is 2^CHANNEL_BITS - 1.
  localparam int unsigned CHANNEL_BITS = 8;
  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

  localparam int unsigned HUE_BITS  = 16;
  localparam int unsigned FIX_BITS  = 17;
  localparam int unsigned FRAC_BITS = 12;

  // Hue in 1/64 degree: one 60 degree sector and the full circle.
  localparam int unsigned HUE_SECTOR = 3840;
  localparam int unsigned HUE_FULL   = 6 * HUE_SECTOR;

  // 1.0 times one sector, the scale of the bracketed term (1 - s*k/3840).
  localparam logic [27:0] FULL_SCALE = 28'd251658240;

  localparam int unsigned SK_BITS   = FIX_BITS + FRAC_BITS;
  localparam int unsigned TERM_BITS = 30;
  localparam int unsigned PROD_BITS = TERM_BITS + FIX_BITS + 1;

  // 1.0 on the product scale is 2^32 * 3840 = 15 * 2^40.
  localparam int unsigned POS_BITS   = 44;
  localparam int unsigned DIV_SHIFT  = 40;
  localparam logic signed [PROD_BITS-1:0] ONE_PROD = PROD_BITS'(64'd15) << DIV_SHIFT;

  // Rounding sum x*MAX + 1.0/2 and the quotient by 15 through a reciprocal.
  localparam int unsigned SUM_BITS   = POS_BITS + CHANNEL_BITS;
  localparam logic [SUM_BITS-1:0] HALF_PROD = SUM_BITS'(64'd15) << (DIV_SHIFT - 1);
  localparam int unsigned QUO_BITS   = CHANNEL_BITS + 4;
  localparam int unsigned RECIP_SHIFT = CHANNEL_BITS + 8;
  localparam int unsigned RECIP_BITS = CHANNEL_BITS + 5;
  localparam logic [RECIP_BITS-1:0] RECIP_MUL =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);

  // Queue between front and back; the depth must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // Which of v, t, p or q a channel takes.
  typedef enum logic [1:0] {
    TERM_V,
    TERM_T,
    TERM_P,
    TERM_Q
  } term_e;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [FIX_BITS-1:0] saturation;
    logic [FIX_BITS-1:0] brightness;
  } in_word_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } out_word_t;

  // Classified word: each channel is v * (1.0 - s * k / 3840); index 0 is red.
  typedef struct packed {
    logic [FIX_BITS-1:0]                saturation;
    logic [FIX_BITS-1:0]                brightness;
    logic [2:0][FRAC_BITS-1:0]          k;
  } cmd_t;

  // Multiplier k of s for a term, given the fraction and its complement.
  function automatic logic [FRAC_BITS-1:0] term_k(
    input term_e               term,
    input logic [FRAC_BITS-1:0] frac,
    input logic [FRAC_BITS-1:0] rest
  );
    logic [FRAC_BITS-1:0] k;
    unique case (term)
      TERM_V:  k = '0;
      TERM_T:  k = rest;
      TERM_P:  k = FRAC_BITS'(HUE_SECTOR);
      TERM_Q:  k = frac;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/hsv_to_rgb_pixel_top.sv @@
// Top level of the HSV to RGB pixel converter: front end, queue and arithmetic back end.
//
// Usage: each word on the input channel (in_valid_i / in_ready_o / in_word_i) is one
// colour: hue in 1/64 degree (23040 and above wrap to 0), saturation and brightness
// as unsigned fixed point with 65536 meaning 1.0. Each input word yields exactly one
// output word on out_valid_o / out_ready_i / out_word_o with 8-bit red, green and blue,
// rounded half up and clamped to 0..255.
//
// From the accepting edge a word passes one front register, one queue slot, and three
// arithmetic stages feeding the output register before out_valid_o rises. Throughput
// is one word per cycle while the output is taken; the arithmetic stages each hold
// one multiplier or one wide add, and every stage takes a new word every cycle.
//
// When the receiver holds out_ready_i low, the back end pipeline stops as a whole
// and the 4-word queue keeps absorbing what the front end classifies, so the input
// keeps flowing until the queue fills; in_ready_o then drops. Reset clears all valid
// flags and the queue pointers, so no stale word is ever delivered.
module hsv_to_rgb_pixel_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hsv2rgb_pkg::in_word_t  in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hsv2rgb_pkg::out_word_t out_word_o
);
  import hsv2rgb_pkg::*;

  logic fe_valid, fe_ready;
  cmd_t fe_cmd;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  // Classify the hue into a sector and pick the term for each channel.
  hsv2rgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  // Decouples the front end from stalls at the output.
  hsv2rgb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fe_valid),
    .push_ready_o (fe_ready),
    .push_cmd_i   (fe_cmd),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd)
  );

  // Multiply, round by the channel full scale, and clamp.
  hsv2rgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/hsv2rgb_front.sv @@
// Front end: accepts pixels, splits the hue into sector and fraction, picks terms.
module hsv2rgb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hsv2rgb_pkg::in_word_t in_word_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output hsv2rgb_pkg::cmd_t     cmd_o
);
  import hsv2rgb_pkg::*;

  logic                 valid_q, valid_d;
  cmd_t                 cmd_q, cmd_d;
  logic [HUE_BITS-1:0]  hue_w, base;
  logic [2:0]           sector;
  logic [FRAC_BITS-1:0] frac, rest;
  term_e                t_red, t_green, t_blue;
  logic                 take;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    hue_w = (in_word_i.hue >= HUE_BITS'(HUE_FULL)) ? '0 : in_word_i.hue;
    priority if (hue_w < HUE_BITS'(HUE_SECTOR)) begin
      sector = 3'd0;
      base   = '0;
    end else if (hue_w < HUE_BITS'(2 * HUE_SECTOR)) begin
      sector = 3'd1;
      base   = HUE_BITS'(HUE_SECTOR);
    end else if (hue_w < HUE_BITS'(3 * HUE_SECTOR)) begin
      sector = 3'd2;
      base   = HUE_BITS'(2 * HUE_SECTOR);
    end else if (hue_w < HUE_BITS'(4 * HUE_SECTOR)) begin
      sector = 3'd3;
      base   = HUE_BITS'(3 * HUE_SECTOR);
    end else if (hue_w < HUE_BITS'(5 * HUE_SECTOR)) begin
      sector = 3'd4;
      base   = HUE_BITS'(4 * HUE_SECTOR);
    end else begin
      sector = 3'd5;
      base   = HUE_BITS'(5 * HUE_SECTOR);
    end
    frac = FRAC_BITS'(hue_w - base);
    rest = FRAC_BITS'(HUE_SECTOR) - frac;

    unique case (sector)
      3'd0:    begin t_red = TERM_V; t_green = TERM_T; t_blue = TERM_P; end
      3'd1:    begin t_red = TERM_Q; t_green = TERM_V; t_blue = TERM_P; end
      3'd2:    begin t_red = TERM_P; t_green = TERM_V; t_blue = TERM_T; end
      3'd3:    begin t_red = TERM_P; t_green = TERM_Q; t_blue = TERM_V; end
      3'd4:    begin t_red = TERM_T; t_green = TERM_P; t_blue = TERM_V; end
      default: begin t_red = TERM_V; t_green = TERM_P; t_blue = TERM_Q; end
    endcase

    // Zero saturation needs no case of its own: every term reduces to v.
    cmd_d.saturation = in_word_i.saturation;
    cmd_d.brightness = in_word_i.brightness;
    cmd_d.k[0]       = term_k(t_red, frac, rest);
    cmd_d.k[1]       = term_k(t_green, frac, rest);
    cmd_d.k[2]       = term_k(t_blue, frac, rest);
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

@@ rtl/hsv2rgb_queue.sv @@
// Small queue of classified words between the front end and the arithmetic back end.
module hsv2rgb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  hsv2rgb_pkg::cmd_t push_cmd_i,
  input  logic              pop_i,
  output logic              pop_valid_o,
  output hsv2rgb_pkg::cmd_t pop_cmd_o
);
  import hsv2rgb_pkg::*;

  cmd_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_BITS:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign push_ready_o = (count_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_cmd_o    = mem_q[rd_q];

  always_comb begin
    wr_d    = do_push ? wr_q + 1'b1 : wr_q;
    rd_d    = do_pop ? rd_q + 1'b1 : rd_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("back end pops an empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on a push");

endmodule

@@ rtl/hsv2rgb_back.sv @@
// Back end: four-stage arithmetic pipeline forming, rounding and clamping the channels.
module hsv2rgb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_pop_o,
  input  hsv2rgb_pkg::cmd_t      cmd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hsv2rgb_pkg::out_word_t out_word_o
);
  import hsv2rgb_pkg::*;

  logic                         adv;
  logic                         v1_q, v2_q, v3_q, v4_q;
  logic [FIX_BITS-1:0]          bright_q;
  logic signed [TERM_BITS-1:0]  a_q [3];
  logic signed [TERM_BITS-1:0]  a_d [3];
  logic signed [PROD_BITS-1:0]  x_q [3];
  logic signed [PROD_BITS-1:0]  x_d [3];
  logic [QUO_BITS-1:0]          w_q [3];
  logic [QUO_BITS-1:0]          w_d [3];
  logic                         zero_q [3];
  logic                         zero_d [3];
  logic                         over_q [3];
  logic                         over_d [3];
  chan_t                        ch_d [3];
  out_word_t                    out_q;
  logic [SK_BITS-1:0]           sk;
  logic [SUM_BITS-1:0]          sum;
  logic [QUO_BITS+RECIP_BITS-1:0] quo;

  // The whole pipeline moves together whenever the result register can take a word.
  assign adv       = !v4_q || out_ready_i;
  assign cmd_pop_o = adv && cmd_valid_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sk     = SK_BITS'(cmd_i.saturation) * SK_BITS'(cmd_i.k[c]);
      a_d[c] = $signed({2'b00, FULL_SCALE}) - $signed({1'b0, sk});
      x_d[c] = PROD_BITS'($signed({1'b0, bright_q})) * PROD_BITS'(a_q[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      zero_d[c] = x_q[c][PROD_BITS-1] || (x_q[c] == '0);
      over_d[c] = (x_q[c] >= ONE_PROD);
      sum = {x_q[c][POS_BITS-1:0], CHANNEL_BITS'(0)}
          - {CHANNEL_BITS'(0), x_q[c][POS_BITS-1:0]} + HALF_PROD;
      w_d[c] = sum[SUM_BITS-1:DIV_SHIFT];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quo = (QUO_BITS+RECIP_BITS)'(w_q[c]) * (QUO_BITS+RECIP_BITS)'(RECIP_MUL);
      priority if (zero_q[c]) begin
        ch_d[c] = '0;
      end else if (over_q[c]) begin
        ch_d[c] = CHAN_MAX;
      end else begin
        ch_d[c] = quo[RECIP_SHIFT +: CHANNEL_BITS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= cmd_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bright_q <= cmd_i.brightness;
      for (int c = 0; c < 3; c++) begin
        a_q[c]    <= a_d[c];
        x_q[c]    <= x_d[c];
        w_q[c]    <= w_d[c];
        zero_q[c] <= zero_d[c];
        over_q[c] <= over_d[c];
      end
      out_q.red   <= ch_d[0];
      out_q.green <= ch_d[1];
      out_q.blue  <= ch_d[2];
    end
  end

  assign out_valid_o = v4_q;
  assign out_word_o  = out_q;

  a_pop_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> v1_q)
    else $error("popped word did not enter the first stage");

  a_zero_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q && zero_q[0]) |=> (out_q.red == '0))
    else $error("negative or zero red term not cleared");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q) |=> v4_q)
    else $error("word lost between the last two stages");

endmodule

@@ sim/hsv_to_rgb_pixel_checker.sv @@
// Scoreboard for the HSV to RGB pixel converter: watches both channels and checks every RGB word.
`timescale 1ns / 100ps
module hsv_to_rgb_pixel_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  hsv2rgb_pkg::in_word_t  in_word_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  hsv2rgb_pkg::out_word_t out_word_i,
  output int                     mismatches_o,
  output int                     pending_o,
  output int                     checked_o
);
  import hsv2rgb_pkg::*;

  // Fixed-point scales, kept as signed 64-bit so no unsigned package constant leaks in.
  localparam longint UNIT_L     = 65536;
  localparam longint SECTOR_L   = longint'(HUE_SECTOR);
  localparam longint HUE_FULL_L = longint'(HUE_FULL);
  // A channel of 1.0 on the scale of v * (1.0 - s * k / 3840).
  localparam longint CHAN_ONE   = longint'(65536) * 65536 * 3840;

  out_word_t rgb_expected_q[$];

  // Round half up to the channel code and clamp to 0..full scale.
  function automatic chan_t scale_channel(longint x);
    longint top_code;
    top_code = (longint'(1) << CHANNEL_BITS) - 1;
    if (x <= 0) return '0;
    if (x >= CHAN_ONE) return CHAN_MAX;
    return chan_t'((2 * x * top_code + CHAN_ONE) / (2 * CHAN_ONE));
  endfunction

  function automatic out_word_t predict_rgb(in_word_t w);
    longint    h, s, v, sector, frac;
    longint    tv, tp, tq, tt;
    term_e     pick [3];
    longint    level [3];
    out_word_t rgb;
    int        c;
    h = w.hue;
    s = w.saturation;
    v = w.brightness;
    if (h >= HUE_FULL_L) h = 0;
    sector = h / SECTOR_L;
    frac   = h % SECTOR_L;
    tv = v * UNIT_L * SECTOR_L;
    tp = v * (UNIT_L - s) * SECTOR_L;
    tq = v * (UNIT_L * SECTOR_L - s * frac);
    tt = v * (UNIT_L * SECTOR_L - s * (SECTOR_L - frac));
    if (s == 0) begin
      pick = '{TERM_V, TERM_V, TERM_V};
    end else begin
      case (sector)
        0: pick = '{TERM_V, TERM_T, TERM_P};
        1: pick = '{TERM_Q, TERM_V, TERM_P};
        2: pick = '{TERM_P, TERM_V, TERM_T};
        3: pick = '{TERM_P, TERM_Q, TERM_V};
        4: pick = '{TERM_T, TERM_P, TERM_V};
        default: pick = '{TERM_V, TERM_P, TERM_Q};
      endcase
    end
    for (c = 0; c < 3; c++) begin
      case (pick[c])
        TERM_V:  level[c] = tv;
        TERM_T:  level[c] = tt;
        TERM_P:  level[c] = tp;
        default: level[c] = tq;
      endcase
    end
    rgb.red   = scale_channel(level[0]);
    rgb.green = scale_channel(level[1]);
    rgb.blue  = scale_channel(level[2]);
    return rgb;
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) rgb_expected_q.push_back(predict_rgb(in_word_i));
      if (out_valid_i && out_ready_i) begin
        if (rgb_expected_q.size() == 0) begin
          $display("%0t: unexpected word r=%0d g=%0d b=%0d", $time,
                   out_word_i.red, out_word_i.green, out_word_i.blue);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = rgb_expected_q.pop_front();
          if (want != out_word_i) begin
            if (want.red != out_word_i.red)
              $display("%0t: red expected %0d got %0d", $time, want.red, out_word_i.red);
            if (want.green != out_word_i.green)
              $display("%0t: green expected %0d got %0d", $time,
                       want.green, out_word_i.green);
            if (want.blue != out_word_i.blue)
              $display("%0t: blue expected %0d got %0d", $time, want.blue, out_word_i.blue);
            mismatches_o <= mismatches_o + 1;
          end
          checked_o <= checked_o + 1;
        end
      end
    end
    pending_o <= rgb_expected_q.size();
  end

endmodule

@@ sim/hsv_to_rgb_pixel_top_test.sv @@
// Top of the HSV to RGB pixel converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module hsv_to_rgb_pixel_top_test;
  import hsv2rgb_pkg::*;

  // A long receiver hold-off must fill the queue and the pipeline well before it ends.
  localparam int unsigned LONG_STALL     = 400;
  localparam int unsigned STALL_BURST    = 40;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned PHASE_WORDS    = 340;
  // Longest correct quiet stretch is the long hold-off; allow it many times over.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // Idling mixes for the random phases: sender idle and receiver stall, in percent.
  localparam int unsigned SEND_IDLE [4] = '{0, 79, 0, 7};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 79, 7};

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  int          mismatches;
  int          pending;
  int          checked;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  logic        hold_request = 1'b0;
  logic        hold_taken   = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned words_sent   = 0;
  int unsigned quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  hsv_to_rgb_pixel_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  hsv_to_rgb_pixel_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver. It normally stalls at random with the current percentage. The first
  // time the stimulus raises hold_request it drops ready while a count loaded from
  // LONG_STALL runs down here, so the block backs up all the way to its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      out_ready_i <= 1'b0;
      hold_left   <= LONG_STALL;
      hold_taken  <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("hsv_to_rgb_pixel_top test failed");
      $finish;
    end
  end

  function automatic in_word_t make_word(int unsigned h, int unsigned s, int unsigned v);
    in_word_t w;
    w.hue        = HUE_BITS'(h);
    w.saturation = FIX_BITS'(s);
    w.brightness = FIX_BITS'(v);
    return w;
  endfunction

  // Saturation or value: mostly within 0..1.0, with zero, exactly 1.0, values just
  // around 1.0 and the whole 17-bit range (above 1.0) mixed in.
  function automatic logic [FIX_BITS-1:0] random_level();
    int unsigned x;
    case ($urandom_range(9))
      0:       x = 0;
      1:       x = 65536;
      2:       x = 65533 + $urandom_range(6);
      3, 4:    x = $urandom_range(131071);
      default: x = $urandom_range(65536);
    endcase
    return FIX_BITS'(x);
  endfunction

  // Hue: mostly a legal angle, some at or above the wrap point and some right at a
  // sector boundary where the fraction is at its ends.
  function automatic in_word_t random_hsv();
    int unsigned h;
    case ($urandom_range(9))
      0:       h = $urandom_range(65535);
      1:       h = HUE_FULL + $urandom_range(65535 - HUE_FULL);
      2:       h = $urandom_range(1, 6) * HUE_SECTOR - 1 + $urandom_range(2);
      default: h = $urandom_range(HUE_FULL - 1);
    endcase
    return make_word(h, random_level(), random_level());
  endfunction

  // Offer one word, after a random idle gap, and hold it until it is taken.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Stop offering and wait until every predicted RGB word has come back. The first
  // edge lets the checker count the word accepted at this very edge.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Corner words: pure red and mid-sector hues at full saturation and value, the
  // ends of the fraction, the wrap of the hue circle, grey, black, and saturation
  // and value above 1.0 so that terms go negative or past full scale.
  task automatic send_directed();
    int k;
    send_word(make_word(0, 65536, 65536));
    for (k = 0; k < 6; k++) send_word(make_word(k * HUE_SECTOR + 1920, 65536, 65536));
    send_word(make_word(HUE_SECTOR - 1, 65536, 65536));
    send_word(make_word(HUE_SECTOR, 65536, 65536));
    send_word(make_word(HUE_FULL - 1, 65536, 65536));
    send_word(make_word(HUE_FULL, 65536, 65536));
    send_word(make_word(65535, 40000, 50000));
    send_word(make_word(10000, 0, 40000));
    send_word(make_word(0, 0, 0));
    send_word(make_word(7000, 65536, 0));
    send_word(make_word(5000, 100000, 65536));
    send_word(make_word(20000, 131071, 131071));
    send_word(make_word(13000, 30000, 131071));
    send_word(make_word(1, 1, 1));
    send_word(make_word(11519, 65535, 65535));
    send_word(make_word(0, 131071, 65536));
    send_word(make_word(19200, 32768, 32768));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();
    wait_drained();

    // Hold the output off for a long stretch while the sender keeps pushing: the
    // queue fills, in_ready_o drops, and the backlog drains once ready returns.
    hold_request <= 1'b1;
    repeat (STALL_BURST) send_word(random_hsv());
    wait_drained();

    for (int m = 0; m < 4; m++) begin
      idle_pct  = SEND_IDLE[m];
      stall_pct <= RECV_STALL[m];
      repeat (PHASE_WORDS) send_word(random_hsv());
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Converted %0d colours: corners of every hue sector, wrapped hues, grey,",
             words_sent);
    $display("over-range s and v; %0d RGB words checked under four idle mixes and a long stall.",
             checked);
    if (mismatches == 0) begin
      $display("hsv_to_rgb_pixel_top test passed");
    end else begin
      $display("hsv_to_rgb_pixel_top test failed");
    end
    $finish;
  end

endmodule

@@ hsv_to_rgb_pixel_top.f @@
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_front.sv
rtl/hsv2rgb_queue.sv
rtl/hsv2rgb_back.sv
rtl/hsv_to_rgb_pixel_top.sv
sim/hsv_to_rgb_pixel_checker.sv
sim/hsv_to_rgb_pixel_top_test.sv
